FILE: rtl/smsc_pkg.sv
package smsc_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int THRESH_W    = 23;
  localparam int COEF_W      = 18;
  localparam int WIN_W       = 16;
  localparam int LEVEL_W     = 24;
  localparam int DB_W        = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - DB_W;

  // log2 datapath
  localparam int LOG_ROUNDS  = 16;
  localparam int MANT_W      = 31;
  localparam int EXP_W       = 5;
  localparam int FRAC_W      = LOG_ROUNDS;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD    = 8'd0,
    REG_SPRING_COS   = 8'd1,
    REG_SPRING_SINC  = 8'd2,
    REG_WINDOW_LIMIT = 8'd3
  } cfg_reg_t;

  localparam logic [THRESH_W-1:0]      THRESHOLD_RST    = 23'h7FFFFF;
  localparam logic signed [COEF_W-1:0] SPRING_COS_RST   = 18'sd65536;
  localparam logic signed [COEF_W-1:0] SPRING_SINC_RST  = 18'sd65536;
  localparam logic [WIN_W-1:0]         WINDOW_LIMIT_RST = 16'd6000;

  localparam logic [LEVEL_W-1:0] METER_FLOOR = 24'd84;
  localparam logic [EXP_W-1:0]   LOG_OFFSET  = 5'd23;
  localparam logic [22:0]        DB_SCALE    = 23'd6313057;
  localparam logic [12:0]        DB_MIN_MAG  = 13'd1600;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } clip_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]         level;
  } meter_word_t;

endpackage

FILE: rtl/smsc_clip.sv
module smsc_clip import smsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [THRESH_W-1:0]        threshold,
  input  logic signed [COEF_W-1:0]   spring_cos,
  input  logic signed [COEF_W-1:0]   spring_sinc,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output clip_word_t                 out_word
);

  localparam int WIDE_W = SAMPLE_W + 1;
  localparam int PROD_W = COEF_W + WIDE_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SHIFT  = 16;
  localparam int SUM_W  = ACC_W - SHIFT + 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-8388608);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] x1_r, p1_r, x2_r;
  logic signed [PROD_W-1:0]   pc2_r, ps2_r;
  logic                       hi2_r, lo2_r;
  clip_word_t                 word3_r;

  logic signed [WIDE_W-1:0] x_w, p_w, t_w, a_w, d_w;
  logic                     hi_nxt, lo_nxt;
  logic signed [PROD_W-1:0] pc_nxt, ps_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  quo, t_s, y_sum;
  logic signed [SAMPLE_W-1:0] y_sat;
  clip_word_t               word_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: threshold test and the two spring products
  always_comb begin
    x_w    = WIDE_W'(x1_r);
    p_w    = WIDE_W'(p1_r);
    t_w    = $signed({2'b00, threshold});
    hi_nxt = x_w > t_w;
    lo_nxt = x_w < -t_w;
    a_w    = hi_nxt ? (p_w - t_w) : (p_w + t_w);
    d_w    = x_w - p_w;
    pc_nxt = PROD_W'(spring_cos) * PROD_W'(a_w);
    ps_nxt = PROD_W'(spring_sinc) * PROD_W'(d_w);
  end

  // stage 2: round half up, drop 16 fraction bits, add back the threshold, saturate
  always_comb begin
    acc   = ACC_W'(pc2_r) + ACC_W'(ps2_r) + ACC_W'(32768);
    quo   = SUM_W'(acc >>> SHIFT);
    t_s   = $signed({{(SUM_W-THRESH_W){1'b0}}, threshold});
    y_sum = hi2_r ? (quo + t_s) : (quo - t_s);
    if (y_sum > SAT_MAX) begin
      y_sat = SAMPLE_W'(SAT_MAX);
    end else if (y_sum < SAT_MIN) begin
      y_sat = SAMPLE_W'(SAT_MIN);
    end else begin
      y_sat = y_sum[SAMPLE_W-1:0];
    end
    word_nxt.clipped = hi2_r || lo2_r;
    word_nxt.sample  = word_nxt.clipped ? y_sat : x2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      prev_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (in_valid && rdy1) prev_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= in_sample;
      p1_r <= prev_r;
    end
    if (rdy2) begin
      x2_r  <= x1_r;
      pc2_r <= pc_nxt;
      ps2_r <= ps_nxt;
      hi2_r <= hi_nxt;
      lo2_r <= lo_nxt;
    end
    if (rdy3) word3_r <= word_nxt;
  end

  assign out_valid = v3_r;
  assign out_word  = word3_r;

endmodule

FILE: rtl/smsc_meter.sv
module smsc_meter import smsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIN_W-1:0]   window_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  clip_word_t         in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output meter_word_t        out_word
);

  logic               v_r;
  logic               rdy;
  logic [WIN_W-1:0]   count_r, count_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  meter_word_t        word_r;

  logic [LEVEL_W-1:0] gain, peak_max, level;
  logic [WIN_W:0]     cnt_inc;
  logic               win_end;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    if (!in_word.clipped) begin
      gain = '0;
    end else if (in_word.sample[SAMPLE_W-1]) begin
      gain = LEVEL_W'(-in_word.sample);
    end else begin
      gain = LEVEL_W'(in_word.sample);
    end
    cnt_inc  = {1'b0, count_r} + (WIN_W+1)'(1);
    win_end  = cnt_inc >= {1'b0, window_limit};
    peak_max = (gain > peak_r) ? gain : peak_r;
    // window end reports this word's gain alone and restarts the peak
    level     = win_end ? gain : peak_max;
    peak_nxt  = win_end ? '0 : peak_max;
    count_nxt = win_end ? '0 : cnt_inc[WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      count_r <= '0;
      peak_r  <= '0;
    end else begin
      if (rdy) v_r <= in_valid;
      if (in_valid && rdy) begin
        count_r <= count_nxt;
        peak_r  <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      word_r.sample <= in_word.sample;
      word_r.level  <= level;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

FILE: rtl/smsc_log.sv
module smsc_log import smsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  meter_word_t                in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic signed [DB_W-1:0]     out_db
);

  localparam int NSQ    = LOG_ROUNDS;
  localparam int NS     = NSQ + 3;
  localparam int SC_IDX = NSQ + 1;
  localparam int OUT_IDX = NSQ + 2;
  localparam int SQ_W   = 2 * MANT_W;
  localparam int NEG_W  = EXP_W + FRAC_W;
  localparam int PROD_W = NEG_W + 23;
  localparam int RND_SH = 32;
  localparam int MAG_W  = PROD_W + 1 - RND_SH;

  typedef struct packed {
    logic [MANT_W-1:0]          mant;
    logic [FRAC_W-1:0]          frac;
    logic [EXP_W-1:0]           expo;
    logic                       low;
    logic signed [SAMPLE_W-1:0] sample;
  } log_stage_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  log_stage_t st_r   [0:NSQ];
  log_stage_t st_nxt [0:NSQ];

  logic [PROD_W-1:0]          prod_r;
  logic                       low_sc_r;
  logic signed [SAMPLE_W-1:0] sample_sc_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [DB_W-1:0]     out_db_r;

  logic [NEG_W-1:0]   neg;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W:0]    rnd_sum;
  logic [MAG_W-1:0]   mag, mag_clamp;
  logic signed [DB_W-1:0] db_nxt;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end
  assign in_ready = rdy[0];

  // normalize, then one squaring per stage yields one fraction bit of log2
  always_comb begin
    logic [SQ_W-1:0]   sq;
    logic [MANT_W:0]   sh;
    logic [EXP_W-1:0]  e;
    e = '0;
    for (int b = 0; b < LEVEL_W; b++) begin
      if (in_word.level[b]) e = EXP_W'(b);
    end
    st_nxt[0].expo   = e;
    st_nxt[0].mant   = MANT_W'(in_word.level) << (EXP_W'(MANT_W - 1) - e);
    st_nxt[0].frac   = '0;
    st_nxt[0].low    = in_word.level < METER_FLOOR;
    st_nxt[0].sample = in_word.sample;
    for (int k = 1; k <= NSQ; k++) begin
      sq = SQ_W'(st_r[k-1].mant) * SQ_W'(st_r[k-1].mant);
      sh = sq[MANT_W-1 +: MANT_W+1];
      st_nxt[k] = st_r[k-1];
      if (sh[MANT_W]) begin
        st_nxt[k].mant = sh[MANT_W:1];
        st_nxt[k].frac[FRAC_W-k] = 1'b1;
      end else begin
        st_nxt[k].mant = sh[MANT_W-1:0];
      end
    end
  end

  // distance below full scale in Q16 log2, scaled to 1/16 dB
  always_comb begin
    neg      = {LOG_OFFSET, {FRAC_W{1'b0}}} - {st_r[NSQ].expo, st_r[NSQ].frac};
    prod_nxt = PROD_W'(neg) * PROD_W'(DB_SCALE);
    rnd_sum  = {1'b0, prod_r} + ((PROD_W+1)'(1) << (RND_SH - 1));
    mag      = rnd_sum[PROD_W:RND_SH];
    mag_clamp = (mag > MAG_W'(DB_MIN_MAG)) ? MAG_W'(DB_MIN_MAG) : mag;
    db_nxt   = low_sc_r ? '0 : -$signed(DB_W'(mag_clamp));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NSQ; k++) begin
      if (rdy[k]) st_r[k] <= st_nxt[k];
    end
    if (rdy[SC_IDX]) begin
      prod_r      <= prod_nxt;
      low_sc_r    <= st_r[NSQ].low;
      sample_sc_r <= st_r[NSQ].sample;
    end
    if (rdy[OUT_IDX]) begin
      out_sample_r <= sample_sc_r;
      out_db_r     <= db_nxt;
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_sample = out_sample_r;
  assign out_db     = out_db_r;

endmodule

FILE: rtl/spring_mass_soft_clipper.sv
// Spring-mass soft clipper with a clipped-peak meter.
// Input stream: in_tdata carries one signed Q1.23 sample per word. Samples
// inside +/- threshold pass unchanged; beyond it the output follows the
// spring-mass path from the previous input sample, saturated to 24 bits.
// Output stream: out_tdata carries the clipped sample and the meter level in
// 1/16 dB (0 below -100 dB). The meter peak restarts every window_limit words.
// Config: cfg_index/cfg_data write threshold (0), spring_cos (1), spring_sinc (2)
// and window_limit (3); cfg_ready is always high. Write only while idle.
// Pipeline: input accept reaches out_tvalid through the clip and meter stages and
// the log2 pipeline (one 31x31 squaring per stage for 16 fraction bits).
// Throughput: one word per cycle while out_tready is high. Every stage has its
// own valid bit, so a stalled receiver holds the output register and back
// pressure reaches in_tready only once the bubbles upstream are filled.
// Reset: registers return to their default values, the previous sample, the
// window count and the peak clear, and the pipeline empties.
module spring_mass_soft_clipper import smsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [23:0] sample_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [23:0] sample_out, [35:24] meter_db, [39:36] zero
);

  logic [THRESH_W-1:0]      threshold_r;
  logic signed [COEF_W-1:0] spring_cos_r;
  logic signed [COEF_W-1:0] spring_sinc_r;
  logic [WIN_W-1:0]         window_limit_r;

  logic        clip_valid, clip_ready;
  clip_word_t  clip_word;
  logic        meter_valid, meter_ready;
  meter_word_t meter_word;

  logic signed [SAMPLE_W-1:0] sample_out;
  logic signed [DB_W-1:0]     meter_db;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      spring_cos_r   <= SPRING_COS_RST;
      spring_sinc_r  <= SPRING_SINC_RST;
      window_limit_r <= WINDOW_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_r    <= cfg_data[THRESH_W-1:0];
        REG_SPRING_COS:   spring_cos_r   <= $signed(cfg_data[COEF_W-1:0]);
        REG_SPRING_SINC:  spring_sinc_r  <= $signed(cfg_data[COEF_W-1:0]);
        REG_WINDOW_LIMIT: window_limit_r <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  smsc_clip u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (threshold_r),
    .spring_cos  (spring_cos_r),
    .spring_sinc (spring_sinc_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   ($signed(in_tdata[SAMPLE_W-1:0])),
    .out_valid   (clip_valid),
    .out_ready   (clip_ready),
    .out_word    (clip_word)
  );

  smsc_meter u_meter (
    .clk          (clk),
    .rst_n        (rst_n),
    .window_limit (window_limit_r),
    .in_valid     (clip_valid),
    .in_ready     (clip_ready),
    .in_word      (clip_word),
    .out_valid    (meter_valid),
    .out_ready    (meter_ready),
    .out_word     (meter_word)
  );

  smsc_log u_log (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (meter_valid),
    .in_ready   (meter_ready),
    .in_word    (meter_word),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (sample_out),
    .out_db     (meter_db)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, meter_db, sample_out};

`ifndef ASSERT_OFF
  a_db_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (meter_db <= 0) && (meter_db >= -$signed({1'b0, DB_MIN_MAG})))
    else $error("meter level out of range");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
